// ----- rtl/core/eiec_pkg.sv -----
// Shared types, constants and a helper function for the external interrupt edge controller.
`timescale 1ns / 1ps

package eiec_pkg;

   localparam int LINE_COUNT  = 16;
   localparam int PORT_COUNT  = 5;
   localparam int PORT_INPUTS = 5;
   localparam int PORT_LIMIT  = (PORT_COUNT < PORT_INPUTS) ? PORT_COUNT : PORT_INPUTS;

   localparam int LINE_W     = 16;
   localparam int FIELD_W    = 4;
   localparam int IRQ_W      = 7;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 24;

   localparam logic [LINE_W-1:0] ALL_LINES =
      LINE_W'((33'd1 << LINE_COUNT) - 33'd1);
   localparam logic [LINE_W-1:0] SHARED_LOW_LINES  = 16'h03E0;
   localparam logic [LINE_W-1:0] SHARED_HIGH_LINES = 16'hFC00;

   typedef enum logic [1:0] {
      ACT_SAMPLE  = 2'd0,
      ACT_CLEAR   = 2'd1,
      ACT_READ    = 2'd2,
      ACT_TRIGGER = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      REG_LINE_MASK  = 3'd0,
      REG_RISING     = 3'd1,
      REG_FALLING    = 3'd2,
      REG_PORT_SEL_0 = 3'd3,
      REG_PORT_SEL_1 = 3'd4,
      REG_PORT_SEL_2 = 3'd5,
      REG_PORT_SEL_3 = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [LINE_W-1:0]        line_mask;
      logic [LINE_W-1:0]        rising_select;
      logic [LINE_W-1:0]        falling_select;
      logic [3:0][LINE_W-1:0]   port_select;
   } cfg_type;

   function automatic logic [IRQ_W-1:0] irq_of(input logic [LINE_W-1:0] pend);
      logic [IRQ_W-1:0] r;
      r      = {2'b00, pend[4:0]};
      r[5]   = |(pend & SHARED_LOW_LINES);
      r[6]   = |(pend & SHARED_HIGH_LINES);
      return r;
   endfunction

endpackage

// ----- rtl/core/eiec_csr.sv -----
// Configuration register file with an APB-style access port.
`timescale 1ns / 1ps

module eiec_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [eiec_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [eiec_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [eiec_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready,
   output eiec_pkg::cfg_type                   cfg
);

   eiec_pkg::cfg_type                 cfg_ff;
   eiec_pkg::cfg_type                 cfg_in;
   logic                              wr_en;
   logic [2:0]                        reg_idx;
   logic [eiec_pkg::LINE_W-1:0]       wval;
   logic [eiec_pkg::LINE_W-1:0]       rval;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[4:2];
   assign wval       = csr_pwdata[eiec_pkg::LINE_W-1:0];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (eiec_pkg::reg_index_type'(reg_idx))
            eiec_pkg::REG_LINE_MASK:  cfg_in.line_mask      = wval;
            eiec_pkg::REG_RISING:     cfg_in.rising_select  = wval;
            eiec_pkg::REG_FALLING:    cfg_in.falling_select = wval;
            eiec_pkg::REG_PORT_SEL_0: cfg_in.port_select[0] = wval;
            eiec_pkg::REG_PORT_SEL_1: cfg_in.port_select[1] = wval;
            eiec_pkg::REG_PORT_SEL_2: cfg_in.port_select[2] = wval;
            eiec_pkg::REG_PORT_SEL_3: cfg_in.port_select[3] = wval;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (eiec_pkg::reg_index_type'(reg_idx))
         eiec_pkg::REG_LINE_MASK:  rval = cfg_ff.line_mask;
         eiec_pkg::REG_RISING:     rval = cfg_ff.rising_select;
         eiec_pkg::REG_FALLING:    rval = cfg_ff.falling_select;
         eiec_pkg::REG_PORT_SEL_0: rval = cfg_ff.port_select[0];
         eiec_pkg::REG_PORT_SEL_1: rval = cfg_ff.port_select[1];
         eiec_pkg::REG_PORT_SEL_2: rval = cfg_ff.port_select[2];
         eiec_pkg::REG_PORT_SEL_3: rval = cfg_ff.port_select[3];
         default:                  rval = '0;
      endcase
   end

   assign csr_prdata = {{(eiec_pkg::CSR_DATA_W - eiec_pkg::LINE_W){1'b0}}, rval};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/core/eiec_core.sv -----
// Input register, edge detection and pending update, and result register.
`timescale 1ns / 1ps

module eiec_core (
   input  logic                                clock,
   input  logic                                reset,
   input  eiec_pkg::cfg_type                   cfg,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [1:0]                          req_action,
   input  logic [4:0][eiec_pkg::LINE_W-1:0]    req_ports,
   input  logic [eiec_pkg::LINE_W-1:0]         req_wbits,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [eiec_pkg::LINE_W-1:0]         rsp_pending,
   output logic [eiec_pkg::IRQ_W-1:0]          rsp_irq
);

   logic                                  in_valid_ff;
   eiec_pkg::action_type                  in_action_ff;
   logic [4:0][eiec_pkg::LINE_W-1:0]      in_ports_ff;
   logic [eiec_pkg::LINE_W-1:0]           in_wbits_ff;

   logic                                  out_valid_ff;
   logic [eiec_pkg::LINE_W-1:0]           out_pending_ff;
   logic [eiec_pkg::IRQ_W-1:0]            out_irq_ff;

   logic [eiec_pkg::LINE_W-1:0]           prev_ff;
   logic [eiec_pkg::LINE_W-1:0]           prev_in;
   logic [eiec_pkg::LINE_W-1:0]           pending_ff;
   logic [eiec_pkg::LINE_W-1:0]           pending_in;

   logic                                  advance;
   logic                                  req_accept;
   logic [eiec_pkg::LINE_W-1:0]           levels;
   logic [eiec_pkg::LINE_W-1:0]           enabled;
   logic [eiec_pkg::LINE_W-1:0]           edges;
   logic [eiec_pkg::FIELD_W-1:0]          field;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;
   assign enabled    = cfg.line_mask & eiec_pkg::ALL_LINES;

   always_comb begin
      levels = '0;
      field  = '0;
      for (int n = 0; n < eiec_pkg::LINE_W; n++) begin
         field = cfg.port_select[n / 4][(n % 4) * eiec_pkg::FIELD_W +: eiec_pkg::FIELD_W];
         if (n < eiec_pkg::LINE_COUNT &&
             field < eiec_pkg::FIELD_W'(eiec_pkg::PORT_LIMIT)) begin
            levels[n] = in_ports_ff[field[2:0]][n];
         end
      end
   end

   assign edges = (~prev_ff & levels & cfg.rising_select) |
                  (prev_ff & ~levels & cfg.falling_select);

   always_comb begin
      prev_in    = prev_ff;
      pending_in = pending_ff;
      case (in_action_ff)
         eiec_pkg::ACT_SAMPLE: begin
            pending_in = pending_ff | (edges & enabled);
            prev_in    = levels;
         end
         eiec_pkg::ACT_CLEAR:   pending_in = pending_ff & ~in_wbits_ff;
         eiec_pkg::ACT_TRIGGER: pending_in = pending_ff | (in_wbits_ff & enabled);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         prev_ff      <= '0;
         pending_ff   <= '0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            prev_ff      <= prev_in;
            pending_ff   <= pending_in;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_action_ff <= eiec_pkg::action_type'(req_action);
         in_ports_ff  <= req_ports;
         in_wbits_ff  <= req_wbits;
      end
      if (advance) begin
         out_pending_ff <= pending_in;
         out_irq_ff     <= eiec_pkg::irq_of(pending_in);
      end
   end

   assign rsp_tvalid  = out_valid_ff;
   assign rsp_pending = out_pending_ff;
   assign rsp_irq     = out_irq_ff;

   a_new_bits_unmasked: assert property (@(posedge clock) disable iff (reset)
      advance |-> ((pending_in & ~pending_ff & ~enabled) == '0))
      else $error("pending bit set on a masked line");

   a_read_keeps_state: assert property (@(posedge clock) disable iff (reset)
      advance && in_action_ff == eiec_pkg::ACT_READ |=>
         $stable(pending_ff) && $stable(prev_ff))
      else $error("read item changed controller state");

   a_result_matches_state: assert property (@(posedge clock) disable iff (reset)
      $past(advance) |-> out_pending_ff == pending_ff)
      else $error("result register out of step with pending state");

   a_irq_matches_pending: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_irq_ff == eiec_pkg::irq_of(out_pending_ff))
      else $error("irq outputs disagree with pending bits");

   a_stage_drains: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_valid_ff |=> out_valid_ff)
      else $error("input stage did not move into empty result stage");

endmodule

// ----- rtl/core/external_interrupt_edge_controller.sv -----
// Top level of the sixteen-line external interrupt edge controller.
//
//   Channel  Direction  Handshake              Contents
//   req      in         req_tvalid/req_tready  tuser: action; tdata: ports A..E, write bits
//   rsp      out        rsp_tvalid/rsp_tready  tdata: pending bits, irq lines
//   csr      in         APB-style, pready high seven 16-bit registers at 4*i
//
// Each accepted item is first held in the input register, then the pending and
// edge-reference update loads the result register.
// A new item is accepted every cycle while the result side takes items.
// Synchronous reset clears configuration, edge reference, pending bits and valids.
// A stalled result holds; the input register keeps one more item behind it.
`timescale 1ns / 1ps

module external_interrupt_edge_controller (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tuser: action [1:0]
   input  logic [1:0]                          req_tuser,
   // tdata: port_a [15:0], port_b [31:16], port_c [47:32], port_d [63:48],
   //        port_e [79:64], write_bits [95:80]
   input  logic [eiec_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // tdata: pending_bits [15:0], irq_lines [22:16], zero [23]
   output logic [eiec_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [eiec_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [eiec_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [eiec_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   eiec_pkg::cfg_type                     cfg;
   logic [4:0][eiec_pkg::LINE_W-1:0]      req_ports;
   logic [eiec_pkg::LINE_W-1:0]           req_wbits;
   logic [eiec_pkg::LINE_W-1:0]           rsp_pending;
   logic [eiec_pkg::IRQ_W-1:0]            rsp_irq;

   assign req_ports = req_tdata[79:0];
   assign req_wbits = req_tdata[95:80];
   assign rsp_tdata = {1'b0, rsp_irq, rsp_pending};

   eiec_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   eiec_core u_core (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_action  (req_tuser),
      .req_ports   (req_ports),
      .req_wbits   (req_wbits),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_pending (rsp_pending),
      .rsp_irq     (rsp_irq)
   );

endmodule

// ----- tb/sv/tb_external_interrupt_edge_controller.sv -----
// Self-checking testbench for the external interrupt edge controller: directed rows, random items.
`timescale 1ns / 1ps

module tb_external_interrupt_edge_controller;
   import eiec_pkg::*;

   typedef struct packed {
      logic [LINE_W-1:0] pend;
      logic [IRQ_W-1:0]  irq;
   } irq_state_t;

   typedef struct packed {
      action_type        act;
      logic [LINE_W-1:0] wbits;
      logic [4:0][15:0]  ports;
   } pin_item_t;

   typedef struct packed {
      bit                is_csr;
      reg_index_type     idx;
      logic [15:0]       val;
      pin_item_t         item;
      bit                fixed;
      irq_state_t        want;
   } dir_row_t;

   localparam logic [79:0] PORTS_HIGH = {5{16'hFFFF}};

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [1:0]            req_tuser;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   logic [LINE_W-1:0]       line_mask_q;
   logic [LINE_W-1:0]       rising_q;
   logic [LINE_W-1:0]       falling_q;
   logic [3:0][LINE_W-1:0]  port_sel_q;
   logic [LINE_W-1:0]       prev_levels_q;
   logic [LINE_W-1:0]       pending_q;

   irq_state_t    expected_pending_q[$];
   dir_row_t      directed_rows[$];
   bit            row_fixed;
   irq_state_t    row_want;
   bit            no_gaps;
   int unsigned   failures;
   int unsigned   results_seen;
   int unsigned   items_taken;
   int unsigned   settings_used;
   int unsigned   act_seen[4];

   external_interrupt_edge_controller u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   initial begin
      #2_000_000;
      $display("tb_external_interrupt_edge_controller NOT OK");
      $finish;
   end

   function automatic irq_state_t latch_pending(input pin_item_t it);
      irq_state_t        r;
      logic [LINE_W-1:0] levels;
      logic [LINE_W-1:0] enabled;
      logic [3:0]        sel;
      enabled = line_mask_q & ALL_LINES;
      levels  = '0;
      case (it.act)
         ACT_SAMPLE: begin
            for (int n = 0; n < LINE_W; n++) begin
               sel = port_sel_q[n / 4][(n % 4) * 4 +: 4];
               for (int p = 0; p < PORT_LIMIT; p++) begin
                  if (int'(sel) == p) levels[n] = it.ports[p][n];
               end
            end
            levels = levels & ALL_LINES;
            pending_q = pending_q | (((~prev_levels_q & levels & rising_q) |
                                      (prev_levels_q & ~levels & falling_q)) & enabled);
            prev_levels_q = levels;
         end
         ACT_CLEAR:   pending_q = pending_q & ~it.wbits;
         ACT_TRIGGER: pending_q = pending_q | (it.wbits & enabled);
         default: ;
      endcase
      r.pend = pending_q;
      r.irq  = {|pending_q[15:10], |pending_q[9:5], pending_q[4:0]};
      return r;
   endfunction

   function automatic int unsigned random_pause(input int unsigned short_pct);
      if ($urandom_range(0, 99) < short_pct) return $urandom_range(1, 3);
      return $urandom_range(8, 20);
   endfunction

   function automatic logic [15:0] random_port_sel();
      logic [15:0] v;
      for (int f = 0; f < 4; f++) begin
         v[f * 4 +: 4] = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, 4))
                                                      : 4'($urandom_range(5, 15));
      end
      return v;
   endfunction

   function automatic logic [15:0] random_bits();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'h0001 << $urandom_range(0, 15);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic pin_item_t random_item();
      pin_item_t   it;
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50)      it.act = ACT_SAMPLE;
      else if (r < 70) it.act = ACT_CLEAR;
      else if (r < 80) it.act = ACT_READ;
      else             it.act = ACT_TRIGGER;
      for (int p = 0; p < 5; p++) it.ports[p] = random_bits();
      it.wbits = random_bits();
      return it;
   endfunction

   function automatic void row_item(input action_type act, input logic [79:0] ports,
                                    input logic [15:0] wbits, input bit fixed,
                                    input logic [15:0] pend, input logic [6:0] irq);
      dir_row_t r;
      r = '0;
      r.item.act   = act;
      r.item.ports = ports;
      r.item.wbits = wbits;
      r.fixed      = fixed;
      r.want.pend  = pend;
      r.want.irq   = irq;
      directed_rows.push_back(r);
   endfunction

   function automatic void row_csr(input reg_index_type idx, input logic [15:0] val);
      dir_row_t r;
      r = '0;
      r.is_csr = 1'b1;
      r.idx    = idx;
      r.val    = val;
      directed_rows.push_back(r);
   endfunction

   task automatic write_reg(input reg_index_type idx, input logic [15:0] val);
      logic [15:0] upper;
      upper = 16'($urandom);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = CSR_ADDR_W'(int'(idx) * 4);
      csr_pwdata  = {upper, val};
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (idx)
         REG_LINE_MASK:  line_mask_q   = val;
         REG_RISING:     rising_q      = val;
         REG_FALLING:    falling_q     = val;
         REG_PORT_SEL_0: port_sel_q[0] = val;
         REG_PORT_SEL_1: port_sel_q[1] = val;
         REG_PORT_SEL_2: port_sel_q[2] = val;
         REG_PORT_SEL_3: port_sel_q[3] = val;
         default: ;
      endcase
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   task automatic wait_drained(input int unsigned tail);
      req_tvalid = 1'b0;
      while (expected_pending_q.size() != 0) @(negedge clock);
      repeat (tail) @(negedge clock);
   endtask

   task automatic send_item(input pin_item_t it, input bit fixed, input irq_state_t want);
      int unsigned gap;
      gap = no_gaps ? 0 : (($urandom_range(0, 99) < 60) ? 0 : random_pause(80));
      if (gap != 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = it.act;
      req_tdata  = {it.wbits, it.ports};
      row_fixed  = fixed;
      row_want   = want;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic set_phase(input int unsigned phase);
      logic [15:0] mask, rise, fall;
      logic [3:0][15:0] sel;
      mask = 16'($urandom);
      rise = 16'($urandom);
      fall = 16'($urandom);
      for (int i = 0; i < 4; i++) sel[i] = random_port_sel();
      case (phase)
         0: begin
            mask = 16'hFFFF;
            rise = 16'hFFFF;
            fall = 16'hFFFF;
         end
         2: begin
            mask = 16'h0000;
            rise = 16'hFFFF;
            fall = 16'hFFFF;
         end
         3: begin
            mask = 16'hFFFF;
            for (int i = 0; i < 4; i++) sel[i] = 16'hFFFF;
         end
         4: begin
            rise = 16'h0000;
            fall = 16'h0000;
            for (int i = 0; i < 4; i++) sel[i] = 16'h4444;
         end
         default: ;
      endcase
      write_reg(REG_LINE_MASK, mask);
      write_reg(REG_RISING, rise);
      write_reg(REG_FALLING, fall);
      write_reg(REG_PORT_SEL_0, sel[0]);
      write_reg(REG_PORT_SEL_1, sel[1]);
      write_reg(REG_PORT_SEL_2, sel[2]);
      write_reg(REG_PORT_SEL_3, sel[3]);
      settings_used++;
   endtask

   always @(posedge clock) begin : result_check
      irq_state_t want;
      pin_item_t  it;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            it.act   = action_type'(req_tuser);
            it.ports = req_tdata[79:0];
            it.wbits = req_tdata[95:80];
            want = latch_pending(it);
            if (row_fixed) want = row_want;
            expected_pending_q.push_back(want);
            items_taken++;
            act_seen[req_tuser]++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_pending_q.size() == 0) begin
               $error("result %h arrived with nothing expected", rsp_tdata);
               failures++;
            end else begin
               want = expected_pending_q.pop_front();
               results_seen++;
               if (rsp_tdata[15:0] !== want.pend) begin
                  $error("pending_bits: expected %h, got %h", want.pend, rsp_tdata[15:0]);
                  failures++;
               end
               if (rsp_tdata[22:16] !== want.irq) begin
                  $error("irq_lines: expected %h, got %h", want.irq, rsp_tdata[22:16]);
                  failures++;
               end
               if (rsp_tdata[23] !== 1'b0) begin
                  $error("pad bit: expected 0, got %b", rsp_tdata[23]);
                  failures++;
               end
            end
         end
      end
   end

   initial begin : result_sink
      int unsigned stall_left;
      int unsigned window;
      bit          calm;
      int unsigned holds_done;
      stall_left = 0;
      window     = 0;
      calm       = 1'b0;
      holds_done = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (window == 0) begin
            calm   = ($urandom_range(0, 2) == 0);
            window = 64;
         end
         window--;
         if ((holds_done == 0 && results_seen >= 100) ||
             (holds_done == 1 && results_seen >= 350)) begin
            holds_done++;
            rsp_tready = 1'b0;
            repeat (60) @(negedge clock);
         end
         if (stall_left != 0) begin
            rsp_tready = 1'b0;
            stall_left--;
         end else if (!calm && $urandom_range(0, 99) < 25) begin
            stall_left = random_pause(85) - 1;
            rsp_tready = 1'b0;
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   initial begin
      irq_state_t none;
      pin_item_t  it;
      none          = '0;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tuser     = '0;
      req_tdata     = '0;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      row_fixed     = 1'b0;
      row_want      = '0;
      no_gaps       = 1'b0;
      failures      = 0;
      results_seen  = 0;
      items_taken   = 0;
      settings_used = 1;
      act_seen      = '{0, 0, 0, 0};
      line_mask_q   = '0;
      rising_q      = '0;
      falling_q     = '0;
      port_sel_q    = '0;
      prev_levels_q = '0;
      pending_q     = '0;

      row_item(ACT_READ,    '0,          16'h0000, 1, 16'h0000, 7'h00);
      row_item(ACT_TRIGGER, '0,          16'hFFFF, 1, 16'h0000, 7'h00);
      row_item(ACT_SAMPLE,  PORTS_HIGH,  16'h0000, 1, 16'h0000, 7'h00);
      row_csr(REG_LINE_MASK, 16'hFFFF);
      row_csr(REG_RISING, 16'hFFFF);
      row_item(ACT_SAMPLE,  '0,          16'h0000, 0, 16'h0000, 7'h00);
      row_item(ACT_SAMPLE,  {64'h0, 16'hFFFF}, 16'h0000, 1, 16'hFFFF, 7'h7F);
      row_item(ACT_CLEAR,   '0,          16'hFFFF, 1, 16'h0000, 7'h00);
      row_item(ACT_TRIGGER, '0,          16'h0001, 1, 16'h0001, 7'h01);
      row_item(ACT_TRIGGER, '0,          16'h0020, 0, 16'h0000, 7'h00);
      row_item(ACT_CLEAR,   '0,          16'hFFFF, 1, 16'h0000, 7'h00);
      row_item(ACT_TRIGGER, PORTS_HIGH,  16'h8000, 1, 16'h8000, 7'h40);
      row_item(ACT_READ,    '0,          16'hFFFF, 0, 16'h0000, 7'h00);
      row_item(ACT_CLEAR,   PORTS_HIGH,  16'h0000, 0, 16'h0000, 7'h00);
      row_item(ACT_SAMPLE,  PORTS_HIGH,  16'h0000, 0, 16'h0000, 7'h00);
      row_csr(REG_RISING, 16'h0000);
      row_csr(REG_FALLING, 16'hFFFF);
      row_item(ACT_SAMPLE,  {64'hFFFF_FFFF_FFFF_FFFF, 16'h0}, 16'h0000, 1, 16'hFFFF, 7'h7F);
      row_item(ACT_CLEAR,   '0,          16'hFFFF, 1, 16'h0000, 7'h00);
      row_csr(REG_LINE_MASK, 16'h00FF);
      row_item(ACT_TRIGGER, '0,          16'hFFFF, 1, 16'h00FF, 7'h3F);
      row_item(ACT_CLEAR,   '0,          16'h00FF, 1, 16'h0000, 7'h00);
      row_csr(REG_LINE_MASK, 16'hFFFF);
      row_csr(REG_RISING, 16'hFFFF);
      row_csr(REG_PORT_SEL_0, 16'hFFFF);
      row_csr(REG_PORT_SEL_1, 16'hFFFF);
      row_csr(REG_PORT_SEL_2, 16'hFFFF);
      row_csr(REG_PORT_SEL_3, 16'hFFFF);
      row_item(ACT_SAMPLE,  PORTS_HIGH,  16'h0000, 1, 16'h0000, 7'h00);
      row_csr(REG_PORT_SEL_0, 16'h4444);
      row_csr(REG_PORT_SEL_1, 16'h4444);
      row_csr(REG_PORT_SEL_2, 16'h4444);
      row_csr(REG_PORT_SEL_3, 16'h4444);
      row_item(ACT_SAMPLE,  {16'h0, 64'hFFFF_FFFF_FFFF_FFFF}, 16'h0000, 0, 16'h0, 7'h00);
      row_item(ACT_SAMPLE,  {16'hFFFF, 64'h0}, 16'h0000, 1, 16'hFFFF, 7'h7F);
      row_item(ACT_CLEAR,   '0,          16'hFFFF, 1, 16'h0000, 7'h00);
      row_csr(REG_PORT_SEL_0, 16'h3210);
      row_csr(REG_PORT_SEL_1, 16'h3210);
      row_csr(REG_PORT_SEL_2, 16'h3210);
      row_csr(REG_PORT_SEL_3, 16'h5555);
      row_item(ACT_SAMPLE,  PORTS_HIGH,  16'h0000, 0, 16'h0000, 7'h00);
      row_item(ACT_SAMPLE,  {16'h0, 16'h8888, 16'h4444, 16'h2222, 16'h1111},
               16'h0000, 0, 16'h0000, 7'h00);
      row_item(ACT_READ,    PORTS_HIGH,  16'h0000, 0, 16'h0000, 7'h00);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_csr) begin
            wait_drained(4);
            write_reg(directed_rows[i].idx, directed_rows[i].val);
         end else begin
            send_item(directed_rows[i].item, directed_rows[i].fixed, directed_rows[i].want);
         end
      end

      for (int unsigned phase = 0; phase < 8; phase++) begin
         wait_drained(4);
         set_phase(phase);
         for (int n = 0; n < 75; n++) begin
            if (n % 25 == 0) no_gaps = ($urandom_range(0, 3) == 0);
            if (n == 30 || $urandom_range(0, 99) == 0) wait_drained(0);
            it = random_item();
            send_item(it, 1'b0, none);
         end
      end

      wait_drained(0);
      repeat (8) @(posedge clock);
      if (expected_pending_q.size() != 0) begin
         $error("%0d results never arrived", expected_pending_q.size());
         failures++;
      end
      $display("Covered %0d items (sample %0d, clear %0d, read %0d, trigger %0d)",
               items_taken, act_seen[ACT_SAMPLE], act_seen[ACT_CLEAR],
               act_seen[ACT_READ], act_seen[ACT_TRIGGER]);
      $display("and checked %0d results over %0d register settings, with %0d failures.",
               results_seen, settings_used, failures);
      if (failures == 0) begin
         $display("tb_external_interrupt_edge_controller OK");
      end else begin
         $display("tb_external_interrupt_edge_controller NOT OK");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/eiec_pkg.sv
rtl/core/eiec_csr.sv
rtl/core/eiec_core.sv
rtl/core/external_interrupt_edge_controller.sv
tb/sv/tb_external_interrupt_edge_controller.sv
